// ===== hw/rtl/atdff_pkg.sv =====
// Shared types, codes and default constants for the top-down first-fit allocator.
// Used by atdff_table and arena_top_down_first_fit_allocator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package atdff_pkg;

  // Fixed field widths.
  localparam int POS_BITS  = 16;
  localparam int NEED_BITS = POS_BITS + 1;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_LIVE_ALLOCS = 32;
  localparam int DEF_HEADER_BYTES    = 24;
  localparam int DEF_ALIGN_BYTES     = 8;
  localparam int DEF_OFFSET_BITS     = 16;

  // Reset value of the arena size register.
  localparam logic [POS_BITS-1:0] ARENA_RESET = 16'd4096;

  // Register index of the arena size register.
  localparam logic REG_ARENA_BYTES = 1'b0;

  // Request kinds.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV_MUL,
    S_DIV_ALIGN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_SLOT,
    PH_FIT,
    PH_FREE
  } phase_t;

  // One live allocation: block start and block end (exclusive).
  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] end_pos;
  } entry_t;

  // Write request into the allocation table.
  typedef struct packed {
    logic   we;
    entry_t wdata;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/atdff_table.sv =====
// Allocation table memory: one write port and one registered read port.
// Depends on atdff_pkg for the entry and write request types.
`timescale 1ns / 1ps
`default_nettype none

module atdff_table
  import atdff_pkg::*;
#(
  parameter int DEPTH    = DEF_MAX_LIVE_ALLOCS,
  parameter int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire tbl_wr_t             wr,
  input  wire logic [IDX_BITS-1:0] waddr,
  input  wire logic [IDX_BITS-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arena_top_down_first_fit_allocator.sv =====
// Top level of the top-down first-fit arena allocator: sequencer, APB register
// and the alignment unit. Depends on atdff_pkg and atdff_table.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request is taken on a rising edge where start is high and busy is low.
// mode 0 allocates request_size payload bytes, mode 1 frees payload_offset.
// Exactly one result follows: done is high for one cycle with status and
// result_offset valid. The receiver cannot hold results off.
// busy stays high from acceptance through the done cycle.
// Each table entry visited goes through a read step and a check step.
// A free with a null offset skips the scan; else it scans entries until the
// match (at most MAX_LIVE_ALLOCS).
// An allocate first scans for a free slot, then runs overlap passes over all
// MAX_LIVE_ALLOCS entries; every collision moves the candidate below the
// colliding block through the alignment multiplier. A pass that moved nothing
// ends the search; each live block moves the candidate at most once, so at
// most MAX_LIVE_ALLOCS passes run. With 32 entries the longest allocate has
// the last slot free and a move for each of 31 live blocks. After reset a
// clearing pass over all MAX_LIVE_ALLOCS entries invalidates the table while
// busy is high; arena_bytes returns to 4096 and APB writes are taken
// throughout.
module arena_top_down_first_fit_allocator
  import atdff_pkg::*;
#(
  parameter int MAX_LIVE_ALLOCS = DEF_MAX_LIVE_ALLOCS,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES     = DEF_ALIGN_BYTES,
  parameter int OFFSET_BITS     = DEF_OFFSET_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Request channel.
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode,
  input  wire logic [15:0]         request_size,
  input  wire logic [15:0]         payload_offset,
  // Result channel.
  output logic                     done,
  output logic [2:0]               status,
  output logic [15:0]              result_offset,
  // APB configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int IDX_BITS   = (MAX_LIVE_ALLOCS > 1) ? $clog2(MAX_LIVE_ALLOCS) : 1;
  localparam int CMP_BITS   = (OFFSET_BITS < POS_BITS) ? OFFSET_BITS : POS_BITS;
  localparam int ALIGN_SH   = $clog2(ALIGN_BYTES);
  localparam int SH         = POS_BITS + ALIGN_SH;
  localparam int RECIP_BITS = SH + 1;
  localparam int PROD_BITS  = POS_BITS + RECIP_BITS;
  localparam int ALIGN_BITS = $clog2(ALIGN_BYTES + 1);
  localparam int ALGN_PBITS = POS_BITS + ALIGN_BITS;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + longint'(ALIGN_BYTES) - 64'd1) / longint'(ALIGN_BYTES);

  localparam logic [RECIP_BITS-1:0] RECIP_C = RECIP_BITS'(RECIP);
  localparam logic [ALIGN_BITS-1:0] ALIGN_C = ALIGN_BITS'(ALIGN_BYTES);
  localparam logic [NEED_BITS-1:0]  HDR_C   = NEED_BITS'(HEADER_BYTES);
  localparam logic [IDX_BITS-1:0]   LAST_IDX = IDX_BITS'(MAX_LIVE_ALLOCS - 1);

  // Control registers.
  state_t                state, state_next;
  phase_t                phase, phase_next;
  logic [IDX_BITS-1:0]   idx, idx_next;
  logic [IDX_BITS-1:0]   slot, slot_next;
  logic                  dirty, dirty_next;
  logic                  done_next;
  logic [POS_BITS-1:0]   arena_bytes;

  // Datapath registers.
  logic [POS_BITS-1:0]   pos, pos_next;
  logic [NEED_BITS-1:0]  needed, needed_next;
  logic [POS_BITS-1:0]   diff, diff_next;
  logic [POS_BITS-1:0]   quo, quo_next;
  logic [CMP_BITS-1:0]   want, want_next;
  status_t               status_q, status_next;
  logic [POS_BITS-1:0]   offset_q, offset_next;

  // Table interface.
  tbl_wr_t               wr;
  logic [IDX_BITS-1:0]   waddr;
  entry_t                rd;

  // Datapath terms.
  logic [PROD_BITS-1:0]  prod;
  logic [ALGN_PBITS-1:0] aligned;
  logic [NEED_BITS-1:0]  pos_hi;
  logic [NEED_BITS-1:0]  grant_sum;
  logic [NEED_BITS-1:0]  tag_sum;
  logic                  last;
  logic                  overlap;
  logic                  match;
  logic                  cfg_write;

  atdff_table #(
    .DEPTH    (MAX_LIVE_ALLOCS),
    .IDX_BITS (IDX_BITS)
  ) u_table (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .raddr (idx),
    .rdata (rd)
  );

  // Alignment unit: floor to a multiple of ALIGN_BYTES by reciprocal
  // multiplication, then scale back; one multiplier per sequencer step.
  assign prod    = PROD_BITS'(diff) * PROD_BITS'(RECIP_C);
  assign aligned = ALGN_PBITS'(quo) * ALGN_PBITS'(ALIGN_C);

  // Compare terms for the entry read from the table.
  assign pos_hi    = NEED_BITS'(pos) + needed;
  assign grant_sum = NEED_BITS'(pos) + HDR_C;
  assign tag_sum   = NEED_BITS'(rd.start_pos) + HDR_C;
  assign overlap   = rd.valid && (pos < rd.end_pos) && (pos_hi > NEED_BITS'(rd.start_pos));
  assign match     = rd.valid && (tag_sum[CMP_BITS-1:0] == want);
  assign last      = (idx == LAST_IDX);

  // Sequencer: next state and table requests.
  always_comb begin
    state_next  = state;
    phase_next  = phase;
    idx_next    = idx;
    slot_next   = slot;
    dirty_next  = dirty;
    done_next   = 1'b0;
    pos_next    = pos;
    needed_next = needed;
    diff_next   = diff;
    quo_next    = quo;
    want_next   = want;
    status_next = status_q;
    offset_next = offset_q;
    wr          = '0;
    waddr       = idx;

    case (state)
      S_CLEAR: begin
        wr.we = 1'b1;
        if (last) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          needed_next = HDR_C + NEED_BITS'(request_size);
          want_next   = payload_offset[CMP_BITS-1:0];
          idx_next    = '0;
          offset_next = '0;
          if (mode == MODE_ALLOC) begin
            if (request_size == '0) begin
              status_next = ST_ZERO_SIZE;
              done_next   = 1'b1;
              state_next  = S_DONE;
            end else begin
              phase_next = PH_SLOT;
              state_next = S_READ;
            end
          end else begin
            if (payload_offset[CMP_BITS-1:0] == '0) begin
              status_next = ST_NOT_FOUND;
              done_next   = 1'b1;
              state_next  = S_DONE;
            end else begin
              phase_next = PH_FREE;
              state_next = S_READ;
            end
          end
        end
      end

      S_READ: begin
        state_next = S_CHECK;
      end

      S_CHECK: begin
        case (phase)
          // Look for the lowest free slot, then set up the first candidate.
          PH_SLOT: begin
            if (!rd.valid) begin
              slot_next = idx;
              if (needed > NEED_BITS'(arena_bytes)) begin
                status_next = ST_NO_SPACE;
                done_next   = 1'b1;
                state_next  = S_DONE;
              end else begin
                diff_next  = arena_bytes - needed[POS_BITS-1:0];
                idx_next   = '0;
                dirty_next = 1'b0;
                phase_next = PH_FIT;
                state_next = S_DIV_MUL;
              end
            end else if (last) begin
              status_next = ST_TABLE_FULL;
              done_next   = 1'b1;
              state_next  = S_DONE;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = S_READ;
            end
          end

          // Check the candidate against each live block; on a collision drop below that
          // block and keep scanning, or end with no space if it cannot fit below it.
          PH_FIT: begin
            if (overlap) begin
              if (NEED_BITS'(rd.start_pos) < needed) begin
                status_next = ST_NO_SPACE;
                done_next   = 1'b1;
                state_next  = S_DONE;
              end else begin
                diff_next  = rd.start_pos - needed[POS_BITS-1:0];
                state_next = S_DIV_MUL;
                if (last) begin
                  idx_next   = '0;
                  dirty_next = 1'b0;
                end else begin
                  idx_next   = idx + 1'b1;
                  dirty_next = 1'b1;
                end
              end
            end else if (last) begin
              if (dirty) begin
                idx_next   = '0;
                dirty_next = 1'b0;
                state_next = S_READ;
              end else begin
                wr.we               = 1'b1;
                waddr               = slot;
                wr.wdata.valid      = 1'b1;
                wr.wdata.start_pos  = pos;
                wr.wdata.end_pos    = pos_hi[POS_BITS-1:0];
                status_next         = ST_OK;
                offset_next         = POS_BITS'(grant_sum[CMP_BITS-1:0]);
                done_next           = 1'b1;
                state_next          = S_DONE;
              end
            end else begin
              idx_next   = idx + 1'b1;
              state_next = S_READ;
            end
          end

          // Release the first live entry whose payload offset matches.
          PH_FREE: begin
            if (match) begin
              wr.we       = 1'b1;
              status_next = ST_OK;
              done_next   = 1'b1;
              state_next  = S_DONE;
            end else if (last) begin
              status_next = ST_NOT_FOUND;
              done_next   = 1'b1;
              state_next  = S_DONE;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = S_READ;
            end
          end

          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_DIV_MUL: begin
        quo_next   = prod[SH +: POS_BITS];
        state_next = S_DIV_ALIGN;
      end

      S_DIV_ALIGN: begin
        pos_next   = aligned[POS_BITS-1:0];
        state_next = S_READ;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_SLOT;
      idx   <= '0;
      slot  <= '0;
      dirty <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      idx   <= idx_next;
      slot  <= slot_next;
      dirty <= dirty_next;
      done  <= done_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    needed   <= needed_next;
    diff     <= diff_next;
    quo      <= quo_next;
    want     <= want_next;
    status_q <= status_next;
    offset_q <= offset_next;
  end

  // APB register: arena size.
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes <= ARENA_RESET;
    end else if (cfg_write && (paddr[2] == REG_ARENA_BYTES)) begin
      arena_bytes <= pwdata[POS_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ARENA_BYTES) ? 32'(arena_bytes) : '0;
  assign pready = 1'b1;

  // Outputs.
  assign busy          = (state != S_IDLE);
  assign status        = status_q;
  assign result_offset = offset_q;

  // A result is shown for a single cycle only.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted request always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Only a successful allocate returns a nonzero offset.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (result_offset == '0))
    else $error("nonzero offset with a failing status");

  // The table is written only while a request or the clearing pass is active.
  assert property (@(posedge clk) disable iff (rst) wr.we |-> busy)
    else $error("table write while idle");

endmodule

`default_nettype wire
